[hw/rtl/spj_pkg.sv]
package spj_pkg;

    // Fixed field widths and quotient range.
    localparam int WORD_W     = 32;
    localparam int WIDE_W     = 64;
    // Quotient bits kept by each divider; anything at or above 2**Q_BITS saturates.
    localparam int Q_BITS     = 34;
    localparam int DIV_LAT    = Q_BITS + 1;
    localparam int LATENCY    = DIV_LAT + 5;
    localparam int CFG_ADDR_W = 3;

    localparam logic [WORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FOCAL_X        = 3'd0,
        CFG_FOCAL_Y        = 3'd1,
        CFG_CENTER_X       = 3'd2,
        CFG_CENTER_Y       = 3'd3,
        CFG_BASELINE_FOCAL = 3'd4
    } cfg_addr_t;

    typedef struct packed {
        logic [WORD_W-1:0] focal_x;
        logic [WORD_W-1:0] focal_y;
        logic [WORD_W-1:0] center_x;
        logic [WORD_W-1:0] center_y;
        logic [WORD_W-1:0] baseline_focal;
    } cfg_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] point_x;
        logic signed [WORD_W-1:0] point_y;
        logic signed [WORD_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] pixel_u;
        logic signed [WORD_W-1:0] pixel_v;
        logic signed [WORD_W-1:0] pixel_ur;
        logic signed [WORD_W-1:0] jac_du_dx;
        logic signed [WORD_W-1:0] jac_du_dz;
        logic signed [WORD_W-1:0] jac_dv_dy;
        logic signed [WORD_W-1:0] jac_dv_dz;
        logic signed [WORD_W-1:0] jac_dur_dz;
        logic                     bad_depth;
    } result_t;

    // Magnitudes handed from the front end to the dividers.
    typedef struct packed {
        logic [WIDE_W-1:0] ax;
        logic [WIDE_W-1:0] ay;
        logic [WIDE_W-1:0] ar;
        logic [WIDE_W-1:0] z2;
        logic [WORD_W-1:0] az;
    } mags_t;

    // Result signs and the zero-depth flag, carried alongside the dividers.
    typedef struct packed {
        logic neg_u;
        logic neg_v;
        logic neg_ur;
        logic neg_dudx;
        logic neg_dvdy;
        logic neg_dudz;
        logic neg_dvdz;
        logic neg_durdz;
        logic bad;
    } side_t;

endpackage

[hw/rtl/stereo_pinhole_projection_jacobian_top.sv]
// Stereo pinhole projection with Jacobian. A point (X, Y, Z) in signed fixed
// point is taken on every clock edge where start is high; busy is never
// raised, so a new point may follow in every cycle. Each point yields one
// result, shown on result for exactly one cycle with done high, in order.
// The receiver cannot stall the pipeline and must take each result when
// done is high. The pipeline is made of the restoring dividers, which retire
// one quotient bit per stage, plus three front-end stages (input, multiply,
// sign handling) and two rounding and saturation stages. A zero depth gives
// an all-zero result with bad_depth set. Intrinsics are written through
// cfg_we/cfg_addr/cfg_wdata and must only change while no point is in flight.
module stereo_pinhole_projection_jacobian_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  spj_pkg::point_t                    point,
    output logic                               done,
    output spj_pkg::result_t                   result,
    input  logic                               cfg_we,
    input  logic [spj_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [spj_pkg::WORD_W-1:0]         cfg_wdata
);
    import spj_pkg::*;

    localparam int SH_WIDE_W  = WIDE_W + FRAC_BITS;
    localparam int SH_FOCAL_W = WORD_W + FRAC_BITS;
    localparam int NEAR_N     = 5;
    localparam int FAR_N      = 3;

    cfg_t              cfg_reg;
    logic              accept;
    logic              f_valid;
    mags_t             f_mags;
    side_t             f_side;
    side_t             side_pipe_reg [DIV_LAT];
    logic [DIV_LAT+1:0] valid_pipe_reg;
    logic [1:0]        bad_tail_reg;
    side_t             d_side;

    logic [Q_BITS-1:0]  quo_n [NEAR_N];
    logic [WORD_W-1:0]  rem_n [NEAR_N];
    logic [WORD_W-1:0]  den_n [NEAR_N];
    logic [NEAR_N-1:0]  ovf_n;
    logic [NEAR_N-1:0]  neg_n;
    logic [WORD_W-1:0]  off_n [NEAR_N];
    logic signed [WORD_W-1:0] val_n [NEAR_N];

    logic [Q_BITS-1:0]  quo_f [FAR_N];
    logic [WIDE_W-1:0]  rem_f [FAR_N];
    logic [WIDE_W-1:0]  den_f [FAR_N];
    logic [FAR_N-1:0]   ovf_f;
    logic [FAR_N-1:0]   neg_f;
    logic signed [WORD_W-1:0] val_f [FAR_N];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_FOCAL_X:        cfg_reg.focal_x        <= cfg_wdata;
                CFG_FOCAL_Y:        cfg_reg.focal_y        <= cfg_wdata;
                CFG_CENTER_X:       cfg_reg.center_x       <= cfg_wdata;
                CFG_CENTER_Y:       cfg_reg.center_y       <= cfg_wdata;
                CFG_BASELINE_FOCAL: cfg_reg.baseline_focal <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    spj_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .point  (point),
        .cfg    (cfg_reg),
        .valid  (f_valid),
        .mags   (f_mags),
        .side   (f_side)
    );

    // Dividers by |Z|.
    spj_divider #(.NUM_W(WIDE_W), .DEN_W(WORD_W)) u_div_u (
        .clk(clk), .num(f_mags.ax), .den(f_mags.az),
        .quo(quo_n[0]), .rem(rem_n[0]), .den_out(den_n[0]), .ovf(ovf_n[0])
    );
    spj_divider #(.NUM_W(WIDE_W), .DEN_W(WORD_W)) u_div_v (
        .clk(clk), .num(f_mags.ay), .den(f_mags.az),
        .quo(quo_n[1]), .rem(rem_n[1]), .den_out(den_n[1]), .ovf(ovf_n[1])
    );
    spj_divider #(.NUM_W(WIDE_W), .DEN_W(WORD_W)) u_div_ur (
        .clk(clk), .num(f_mags.ar), .den(f_mags.az),
        .quo(quo_n[2]), .rem(rem_n[2]), .den_out(den_n[2]), .ovf(ovf_n[2])
    );
    spj_divider #(.NUM_W(SH_FOCAL_W), .DEN_W(WORD_W)) u_div_dudx (
        .clk(clk), .num({cfg_reg.focal_x, {FRAC_BITS{1'b0}}}), .den(f_mags.az),
        .quo(quo_n[3]), .rem(rem_n[3]), .den_out(den_n[3]), .ovf(ovf_n[3])
    );
    spj_divider #(.NUM_W(SH_FOCAL_W), .DEN_W(WORD_W)) u_div_dvdy (
        .clk(clk), .num({cfg_reg.focal_y, {FRAC_BITS{1'b0}}}), .den(f_mags.az),
        .quo(quo_n[4]), .rem(rem_n[4]), .den_out(den_n[4]), .ovf(ovf_n[4])
    );

    // Dividers by Z squared.
    spj_divider #(.NUM_W(SH_WIDE_W), .DEN_W(WIDE_W)) u_div_dudz (
        .clk(clk), .num({f_mags.ax, {FRAC_BITS{1'b0}}}), .den(f_mags.z2),
        .quo(quo_f[0]), .rem(rem_f[0]), .den_out(den_f[0]), .ovf(ovf_f[0])
    );
    spj_divider #(.NUM_W(SH_WIDE_W), .DEN_W(WIDE_W)) u_div_dvdz (
        .clk(clk), .num({f_mags.ay, {FRAC_BITS{1'b0}}}), .den(f_mags.z2),
        .quo(quo_f[1]), .rem(rem_f[1]), .den_out(den_f[1]), .ovf(ovf_f[1])
    );
    spj_divider #(.NUM_W(SH_WIDE_W), .DEN_W(WIDE_W)) u_div_durdz (
        .clk(clk), .num({f_mags.ar, {FRAC_BITS{1'b0}}}), .den(f_mags.z2),
        .quo(quo_f[2]), .rem(rem_f[2]), .den_out(den_f[2]), .ovf(ovf_f[2])
    );

    // Signs, zero-depth flag and valid bits travel beside the dividers.
    always_ff @(posedge clk)
    begin
        side_pipe_reg[0] <= f_side;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            side_pipe_reg[i] <= side_pipe_reg[i-1];
        end
        bad_tail_reg <= {bad_tail_reg[0], side_pipe_reg[DIV_LAT-1].bad};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_pipe_reg <= '0;
        end
        else
        begin
            valid_pipe_reg <= {valid_pipe_reg[DIV_LAT:0], f_valid};
        end
    end

    assign d_side = side_pipe_reg[DIV_LAT-1];
    assign neg_n  = {d_side.neg_dvdy, d_side.neg_dudx, d_side.neg_ur,
                     d_side.neg_v, d_side.neg_u};
    assign neg_f  = {d_side.neg_durdz, d_side.neg_dvdz, d_side.neg_dudz};

    // Principal point offsets for the pixel outputs; the Jacobian gets none.
    assign off_n[0] = cfg_reg.center_x;
    assign off_n[1] = cfg_reg.center_y;
    assign off_n[2] = cfg_reg.center_x;
    assign off_n[3] = '0;
    assign off_n[4] = '0;

    for (genvar g = 0; g < NEAR_N; g++)
    begin : g_near
        spj_round #(.DEN_W(WORD_W)) u_round (
            .clk(clk), .quo(quo_n[g]), .rem(rem_n[g]), .den(den_n[g]),
            .ovf(ovf_n[g]), .neg(neg_n[g]), .bad(d_side.bad),
            .offset(off_n[g]), .value(val_n[g])
        );
    end

    for (genvar g = 0; g < FAR_N; g++)
    begin : g_far
        spj_round #(.DEN_W(WIDE_W)) u_round (
            .clk(clk), .quo(quo_f[g]), .rem(rem_f[g]), .den(den_f[g]),
            .ovf(ovf_f[g]), .neg(neg_f[g]), .bad(d_side.bad),
            .offset('0), .value(val_f[g])
        );
    end

    // Result assembly from the registered lane outputs.
    assign done              = valid_pipe_reg[DIV_LAT+1];
    assign result.pixel_u    = val_n[0];
    assign result.pixel_v    = val_n[1];
    assign result.pixel_ur   = val_n[2];
    assign result.jac_du_dx  = val_n[3];
    assign result.jac_dv_dy  = val_n[4];
    assign result.jac_du_dz  = val_f[0];
    assign result.jac_dv_dz  = val_f[1];
    assign result.jac_dur_dz = val_f[2];
    assign result.bad_depth  = bad_tail_reg[1];

`ifndef ASSERT_OFF
    // Every transfer produces its result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result missing after point transfer");

    // No result appears without a transfer the fixed latency earlier.
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching point transfer");

    // The zero-depth flag follows the depth of the matching point.
    a_bad_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.bad_depth == ($past(point.point_z, LATENCY) == 0)))
        else $error("bad_depth does not match the point depth");

    // A zero-depth result carries only zeros.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.bad_depth |-> result.pixel_u == 0 && result.pixel_v == 0
            && result.pixel_ur == 0 && result.jac_du_dx == 0 && result.jac_du_dz == 0
            && result.jac_dv_dy == 0 && result.jac_dv_dz == 0 && result.jac_dur_dz == 0)
        else $error("nonzero field in a zero-depth result");
`endif

endmodule

[hw/rtl/spj_front.sv]
module spj_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  spj_pkg::point_t point,
    input  spj_pkg::cfg_t   cfg,
    output logic            valid,
    output spj_pkg::mags_t  mags,
    output spj_pkg::side_t  side
);
    import spj_pkg::*;

    logic              in_valid_reg;
    point_t            pt_reg;

    logic              p_valid_reg;
    logic [WIDE_W-1:0] ax_p_reg, ay_p_reg, z2_p_reg;
    logic [WIDE_W-1:0] ax_p_next, ay_p_next, z2_p_next;
    logic [WORD_W-1:0] az_p_reg;
    logic              xs_p_reg, ys_p_reg, zs_p_reg, zero_p_reg;
    logic [WORD_W-1:0] xmag, ymag, zmag;

    logic              s_valid_reg;
    mags_t             mags_reg, mags_next;
    side_t             side_reg, side_next;

    logic              xn, yn, rn, bneg, same_sign, ax_ge;
    logic [WIDE_W-1:0] bf_w, ar;

    // Input register: capture the point on every transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pt_reg <= point;
        end
    end

    // Magnitudes and the three 32 by 32 products.
    always_comb
    begin
        xmag = pt_reg.point_x[WORD_W-1] ? $unsigned(-pt_reg.point_x) : $unsigned(pt_reg.point_x);
        ymag = pt_reg.point_y[WORD_W-1] ? $unsigned(-pt_reg.point_y) : $unsigned(pt_reg.point_y);
        zmag = pt_reg.point_z[WORD_W-1] ? $unsigned(-pt_reg.point_z) : $unsigned(pt_reg.point_z);
        ax_p_next = WIDE_W'(cfg.focal_x) * WIDE_W'(xmag);
        ay_p_next = WIDE_W'(cfg.focal_y) * WIDE_W'(ymag);
        z2_p_next = WIDE_W'(zmag) * WIDE_W'(zmag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_p_reg   <= ax_p_next;
        ay_p_reg   <= ay_p_next;
        z2_p_reg   <= z2_p_next;
        az_p_reg   <= zmag;
        xs_p_reg   <= pt_reg.point_x[WORD_W-1];
        ys_p_reg   <= pt_reg.point_y[WORD_W-1];
        zs_p_reg   <= pt_reg.point_z[WORD_W-1];
        zero_p_reg <= (pt_reg.point_z == '0);
    end

    // Signed difference fx*X - bf in sign-magnitude form, and the result signs.
    always_comb
    begin
        xn        = xs_p_reg && (ax_p_reg != '0);
        yn        = ys_p_reg && (ay_p_reg != '0);
        bneg      = (cfg.baseline_focal != '0);
        bf_w      = WIDE_W'(cfg.baseline_focal);
        same_sign = (xn == bneg);
        ax_ge     = (ax_p_reg >= bf_w);
        if (same_sign)
        begin
            ar = ax_p_reg + bf_w;
            rn = xn;
        end
        else if (ax_ge)
        begin
            ar = ax_p_reg - bf_w;
            rn = xn;
        end
        else
        begin
            ar = bf_w - ax_p_reg;
            rn = bneg;
        end
        if (ar == '0)
        begin
            rn = 1'b0;
        end

        mags_next.ax = ax_p_reg;
        mags_next.ay = ay_p_reg;
        mags_next.ar = ar;
        mags_next.z2 = z2_p_reg;
        mags_next.az = az_p_reg;

        side_next.neg_u     = xn ^ zs_p_reg;
        side_next.neg_v     = yn ^ zs_p_reg;
        side_next.neg_ur    = rn ^ zs_p_reg;
        side_next.neg_dudx  = zs_p_reg;
        side_next.neg_dvdy  = zs_p_reg;
        side_next.neg_dudz  = !xn && (ax_p_reg != '0);
        side_next.neg_dvdz  = !yn && (ay_p_reg != '0);
        side_next.neg_durdz = !rn && (ar != '0);
        side_next.bad       = zero_p_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mags_reg <= mags_next;
        side_reg <= side_next;
    end

    assign valid = s_valid_reg;
    assign mags  = mags_reg;
    assign side  = side_reg;

endmodule

[hw/rtl/spj_divider.sv]
module spj_divider #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  logic                        clk,
    input  logic [NUM_W-1:0]            num,
    input  logic [DEN_W-1:0]            den,
    output logic [spj_pkg::Q_BITS-1:0]  quo,
    output logic [DEN_W-1:0]            rem,
    output logic [DEN_W-1:0]            den_out,
    output logic                        ovf
);
    import spj_pkg::*;

    localparam int HI_W  = NUM_W - Q_BITS;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [CMP_W-1:0]  hi_ext, den_ext;
    logic [DEN_W-1:0]  rem_reg [Q_BITS+1];
    logic [DEN_W-1:0]  den_reg [Q_BITS+1];
    logic [Q_BITS-1:0] lq_reg  [Q_BITS+1];
    logic [Q_BITS:0]   ovf_reg;
    logic [DEN_W:0]    trial   [Q_BITS];
    logic [DEN_W:0]    diff    [Q_BITS];
    logic [Q_BITS-1:0] fits;

    // Entry: the part of the numerator above the kept quotient bits must be
    // below the divisor, otherwise the quotient is out of range.
    assign hi_ext  = CMP_W'(num[NUM_W-1:Q_BITS]);
    assign den_ext = CMP_W'(den);

    // One restoring step per stage; quotient bits shift in where numerator bits leave.
    always_comb
    begin
        for (int i = 0; i < Q_BITS; i++)
        begin
            trial[i] = {rem_reg[i], lq_reg[i][Q_BITS-1]};
            diff[i]  = trial[i] - {1'b0, den_reg[i]};
            fits[i]  = (trial[i] >= {1'b0, den_reg[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= DEN_W'(num[NUM_W-1:Q_BITS]);
        lq_reg[0]  <= num[Q_BITS-1:0];
        den_reg[0] <= den;
        ovf_reg[0] <= (hi_ext >= den_ext);
        for (int i = 0; i < Q_BITS; i++)
        begin
            rem_reg[i+1] <= fits[i] ? diff[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
            lq_reg[i+1]  <= {lq_reg[i][Q_BITS-2:0], fits[i]};
            den_reg[i+1] <= den_reg[i];
            ovf_reg[i+1] <= ovf_reg[i];
        end
    end

    assign quo     = lq_reg[Q_BITS];
    assign rem     = rem_reg[Q_BITS];
    assign den_out = den_reg[Q_BITS];
    assign ovf     = ovf_reg[Q_BITS];

endmodule

[hw/rtl/spj_round.sv]
module spj_round #(
    parameter int DEN_W = 32
) (
    input  logic                              clk,
    input  logic [spj_pkg::Q_BITS-1:0]        quo,
    input  logic [DEN_W-1:0]                  rem,
    input  logic [DEN_W-1:0]                  den,
    input  logic                              ovf,
    input  logic                              neg,
    input  logic                              bad,
    input  logic [spj_pkg::WORD_W-1:0]        offset,
    output logic signed [spj_pkg::WORD_W-1:0] value
);
    import spj_pkg::*;

    localparam int QR_W  = Q_BITS + 1;
    localparam int ACC_W = Q_BITS + 3;

    logic                     half_up;
    logic [QR_W-1:0]          qr_reg;
    logic                     ovf_reg, neg_reg, bad_reg;
    logic signed [ACC_W-1:0]  mag_s, sum;
    logic                     in_range;
    logic [WORD_W-1:0]        value_next;
    logic signed [WORD_W-1:0] value_reg;

    // Round to nearest, ties away from zero, on the magnitude.
    assign half_up = ({rem, 1'b0} >= {1'b0, den});

    always_ff @(posedge clk)
    begin
        qr_reg  <= QR_W'(quo) + QR_W'(half_up);
        ovf_reg <= ovf;
        neg_reg <= neg;
        bad_reg <= bad;
    end

    // Apply the sign, add the principal point and clamp to 32 bits; a zero depth gives zero.
    always_comb
    begin
        mag_s    = signed'(ACC_W'(qr_reg));
        sum      = (neg_reg ? -mag_s : mag_s) + signed'(ACC_W'(offset));
        in_range = (&sum[ACC_W-1:WORD_W-1]) || !(|sum[ACC_W-1:WORD_W-1]);
        if (bad_reg)
        begin
            value_next = '0;
        end
        else if (ovf_reg)
        begin
            value_next = neg_reg ? SAT_MIN : SAT_MAX;
        end
        else if (in_range)
        begin
            value_next = sum[WORD_W-1:0];
        end
        else
        begin
            value_next = sum[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= signed'(value_next);
    end

    assign value = value_reg;

endmodule
